### hdl/dhf_pkg.sv
package dhf_pkg;

   localparam int TagWidth   = 16;
   localparam int ConcWidth  = 32;
   localparam int RateWidth  = 31;
   localparam int CoopWidth  = 16;
   localparam int IndexWidth = 3;
   localparam int ExpSteps   = 16;

   // configuration register indexes
   typedef enum logic [IndexWidth-1:0] {
      REG_MAX_RATE = 3'd0,
      REG_CA_DISS  = 3'd1,
      REG_IP_DISS  = 3'd2,
      REG_CA_COOP  = 3'd3,
      REG_IP_COOP  = 3'd4
   } csr_index_type;

   // how a Hill term is resolved
   typedef enum logic [2:0] {
      TERM_LOG,
      TERM_HALF,
      TERM_ZERO,
      TERM_UNDEF,
      TERM_ONE
   } term_type;

   typedef struct packed {
      logic signed [ConcWidth-1:0] calcium_level;
      logic signed [ConcWidth-1:0] ip3_level;
      logic [TagWidth-1:0]         cell_tag;
   } req_type;

   typedef struct packed {
      logic [TagWidth-1:0]  cell_tag_out;
      logic [RateWidth-1:0] flux;
      logic                 undefined_term;
      logic                 saturated;
   } rsp_type;

   // sideband that travels with every pipeline word
   typedef struct packed {
      logic [TagWidth-1:0] tag;
      term_type            kind_ca;
      term_type            kind_ip;
      logic [1:0]          k_ge;
      logic [1:0]          big;
   } side_type;

   // pick the special case of a term from level, constant and exponent
   function automatic term_type classify(input logic [RateWidth-1:0] x,
                                         input logic [RateWidth-1:0] k,
                                         input logic [CoopWidth-1:0] n);
      term_type kind;
      if (n == '0)
         kind = TERM_HALF;
      else if (x == '0 && k == '0)
         kind = TERM_UNDEF;
      else if (x == '0)
         kind = TERM_ZERO;
      else if (k == '0)
         kind = TERM_ONE;
      else
         kind = TERM_LOG;
      return kind;
   endfunction

   // integer square root, used only to build constants
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // 2^(2^-step) in Q1.30 for every step, by repeated square roots of 2.0;
   // entry j-1 holds the root for step j
   function automatic logic [ExpSteps*RateWidth-1:0] exp_roots();
      logic [ExpSteps*RateWidth-1:0] tab;
      logic [63:0]                   c;
      tab = '0;
      c   = 64'd1 << 31;
      for (int j = 0; j < ExpSteps; j++) begin
         c = isqrt64(c << 30);
         tab[j*RateWidth +: RateWidth] = c[RateWidth-1:0];
      end
      return tab;
   endfunction

   localparam logic [ExpSteps*RateWidth-1:0] ExpRoots = exp_roots();

endpackage

### hdl/dual_hill_flux.sv
// channel  | ports                       | word
// ---------+-----------------------------+-----------------------------------
// request  | req_valid/req_ready         | req_data  : levels and cell tag
// response | rsp_valid/rsp_ready         | rsp_data  : tag, flux and flags
// control  | csr_write_enable/csr_index  | csr_data  : register write, no wait
//
// One word enters per cycle while the pipeline is not held; results leave in request order.
// The depth is set by the 16-step log2 squaring chain, the 16-step exp2 root
// chain and the 31-step restoring divider, one step per stage.
// Reset is synchronous, clears the valid bits and loads the control registers with their defaults.
// A waiting response is held in the output register and one more word in a
// skid register; while the skid register is full the whole pipeline holds.
module dual_hill_flux import dhf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [RateWidth-1:0]  csr_data
);

   localparam int LogSteps = 16;
   localparam int DivSteps = 31;
   localparam int SIn      = 0;
   localparam int SPri     = SIn + 1;
   localparam int SNrm     = SPri + 1;
   localparam int SDif     = SNrm + LogSteps + 1;
   localparam int SQ       = SDif + 1;
   localparam int SD       = SQ + ExpSteps + 1;
   localparam int SY       = SD + 1;
   localparam int SH       = SY + DivSteps + 1;
   localparam int SM1      = SH + 1;
   localparam int NStages  = SM1 + 1;

   localparam logic [RateWidth-1:0] One30   = 31'h4000_0000;
   localparam logic [RateWidth-1:0] FluxMax = 31'h7FFF_FFFF;

   // configuration
   logic [RateWidth-1:0] max_rate_ff;
   logic [RateWidth-1:0] ca_diss_ff;
   logic [RateWidth-1:0] ip_diss_ff;
   logic [CoopWidth-1:0] ca_coop_ff;
   logic [CoopWidth-1:0] ip_coop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rate_ff <= 31'd65536;
         ca_diss_ff  <= 31'd65536;
         ip_diss_ff  <= 31'd65536;
         ca_coop_ff  <= 16'd4096;
         ip_coop_ff  <= 16'd4096;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MAX_RATE: max_rate_ff <= csr_data;
            REG_CA_DISS:  ca_diss_ff  <= csr_data;
            REG_IP_DISS:  ip_diss_ff  <= csr_data;
            REG_CA_COOP:  ca_coop_ff  <= csr_data[CoopWidth-1:0];
            REG_IP_COOP:  ip_coop_ff  <= csr_data[CoopWidth-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic skid_valid_ff;
   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   // valid bits and sideband
   logic [NStages-1:0] valid_ff;
   side_type           side_ff [NStages];
   side_type           side_in [NStages];

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (adv)
         valid_ff <= {valid_ff[NStages-2:0], req_valid};
   end

   // lanes: 0 calcium level, 1 calcium constant, 2 IP3 level, 3 IP3 constant
   logic [RateWidth-1:0] ca_x, ip_x;
   logic [RateWidth-1:0] v_in   [4];
   logic [RateWidth-1:0] v_ff   [4];
   logic [RateWidth-1:0] pv_ff  [4];
   logic [4:0]           pp_in  [4];
   logic [4:0]           pp_ff  [4];
   logic [RateWidth-1:0] lm_in  [LogSteps+1][4];
   logic [RateWidth-1:0] lm_ff  [LogSteps+1][4];
   logic [15:0]          lf_in  [LogSteps+1][4];
   logic [15:0]          lf_ff  [LogSteps+1][4];
   logic [4:0]           lp_in  [LogSteps+1][4];
   logic [4:0]           lp_ff  [LogSteps+1][4];
   logic [20:0]          dd_in  [2];
   logic [20:0]          dd_ff  [2];
   logic [1:0]           kge_in;
   logic [1:0]           big_in;
   logic [RateWidth-1:0] ee_in  [ExpSteps+1][2];
   logic [RateWidth-1:0] ee_ff  [ExpSteps+1][2];
   logic [15:0]          ef_in  [ExpSteps+1][2];
   logic [15:0]          ef_ff  [ExpSteps+1][2];
   logic [4:0]           ei_in  [ExpSteps+1][2];
   logic [4:0]           ei_ff  [ExpSteps+1][2];
   logic [62:0]          dv_in  [2];
   logic [62:0]          dv_ff  [2];
   logic [62:0]          dr_in  [DivSteps+1][2];
   logic [62:0]          dr_ff  [DivSteps+1][2];
   logic [30:0]          dn_in  [DivSteps+1][2];
   logic [30:0]          dn_ff  [DivSteps+1][2];
   logic [30:0]          dq_in  [DivSteps+1][2];
   logic [30:0]          dq_ff  [DivSteps+1][2];
   logic [62:0]          ds_in  [DivSteps+1][2];
   logic [62:0]          ds_ff  [DivSteps+1][2];
   logic [RateWidth-1:0] h_in   [2];
   logic [RateWidth-1:0] h_ff   [2];
   logic [31:0]          f1_in;
   logic [31:0]          f1_ff;
   logic [RateWidth-1:0] h2_ff;
   logic [CoopWidth-1:0] coop   [2];

   assign coop[0] = ca_coop_ff;
   assign coop[1] = ip_coop_ff;

   // clamp, classify and carry the sideband
   always_comb begin
      ca_x = req_data.calcium_level[ConcWidth-1] ? '0 : req_data.calcium_level[RateWidth-1:0];
      ip_x = req_data.ip3_level[ConcWidth-1] ? '0 : req_data.ip3_level[RateWidth-1:0];
      side_in[SIn].tag     = req_data.cell_tag;
      side_in[SIn].kind_ca = classify(ca_x, ca_diss_ff, ca_coop_ff);
      side_in[SIn].kind_ip = classify(ip_x, ip_diss_ff, ip_coop_ff);
      side_in[SIn].k_ge    = '0;
      side_in[SIn].big     = '0;
      for (int i = 1; i < NStages; i++) side_in[i] = side_ff[i-1];
      side_in[SDif].k_ge = kge_in;
      side_in[SQ].big    = big_in;
      // a zero value takes the log path as one; its result is overridden
      v_in[0] = (ca_x == '0)       ? 31'd1 : ca_x;
      v_in[1] = (ca_diss_ff == '0) ? 31'd1 : ca_diss_ff;
      v_in[2] = (ip_x == '0)       ? 31'd1 : ip_x;
      v_in[3] = (ip_diss_ff == '0) ? 31'd1 : ip_diss_ff;
   end

   // leading one search, then normalise and run the squaring steps
   always_comb begin
      logic [61:0] sq;
      for (int l = 0; l < 4; l++) begin
         pp_in[l] = '0;
         for (int b = 0; b < RateWidth; b++)
            if (v_ff[l][b]) pp_in[l] = 5'(b);
         lm_in[0][l] = pv_ff[l] << (5'd30 - pp_ff[l]);
         lf_in[0][l] = '0;
         lp_in[0][l] = pp_ff[l];
         for (int j = 1; j <= LogSteps; j++) begin
            sq          = 62'(lm_ff[j-1][l]) * 62'(lm_ff[j-1][l]);
            lm_in[j][l] = sq[61] ? sq[61:31] : sq[60:30];
            lf_in[j][l] = {lf_ff[j-1][l][14:0], sq[61]};
            lp_in[j][l] = lp_ff[j-1][l];
         end
      end
   end

   // log difference, scale by the exponent and split into integer and fraction,
   // then exp2 of the fraction, one root per stage
   always_comb begin
      logic [20:0] lk, lx;
      logic [36:0] sc;
      logic [62:0] pr;
      for (int t = 0; t < 2; t++) begin
         lk        = {lp_ff[LogSteps][2*t+1], lf_ff[LogSteps][2*t+1]};
         lx        = {lp_ff[LogSteps][2*t],   lf_ff[LogSteps][2*t]};
         kge_in[t] = lk >= lx;
         dd_in[t]  = kge_in[t] ? lk - lx : lx - lk;
         sc        = 37'(dd_ff[t]) * 37'(coop[t]) + 37'd2048;
         ee_in[0][t] = One30;
         ef_in[0][t] = sc[27:12];
         ei_in[0][t] = sc[32:28];
         big_in[t]   = |sc[36:33];
         for (int j = 1; j <= ExpSteps; j++) begin
            pr          = 63'(ee_ff[j-1][t]) * 63'(ExpRoots[(j-1)*RateWidth +: RateWidth])
                          + 63'(1 << 29);
            ee_in[j][t] = ef_ff[j-1][t][16-j] ? pr[60:30] : ee_ff[j-1][t];
            ef_in[j][t] = ef_ff[j-1][t];
            ei_in[j][t] = ei_ff[j-1][t];
         end
      end
   end

   // build the divisor, the rounded numerator and run the divider
   always_comb begin
      logic [62:0] nm;
      logic [63:0] rs;
      logic        ge;
      for (int t = 0; t < 2; t++) begin
         dv_in[t]    = 63'(One30) + (63'(ee_ff[ExpSteps][t]) << ei_ff[ExpSteps][t]);
         nm          = (63'd1 << 60) + (dv_ff[t] >> 1);
         dr_in[0][t] = 63'(nm[62:31]);
         dn_in[0][t] = nm[30:0];
         dq_in[0][t] = '0;
         ds_in[0][t] = dv_ff[t];
         for (int j = 1; j <= DivSteps; j++) begin
            rs          = {dr_ff[j-1][t], dn_ff[j-1][t][30]};
            ge          = rs >= {1'b0, ds_ff[j-1][t]};
            dr_in[j][t] = ge ? 63'(rs - {1'b0, ds_ff[j-1][t]}) : rs[62:0];
            dn_in[j][t] = {dn_ff[j-1][t][29:0], 1'b0};
            dq_in[j][t] = {dq_ff[j-1][t][29:0], ge};
            ds_in[j][t] = ds_ff[j-1][t];
         end
      end
   end

   // resolve each Hill term
   always_comb begin
      logic [RateWidth-1:0] u;
      term_type             kind;
      for (int t = 0; t < 2; t++) begin
         kind = (t == 0) ? side_ff[SH-1].kind_ca : side_ff[SH-1].kind_ip;
         u    = dq_ff[DivSteps][t];
         if (u > One30) u = One30;
         if (side_ff[SH-1].big[t]) u = '0;
         case (kind)
            TERM_HALF:  h_in[t] = One30 >> 1;
            TERM_ZERO:  h_in[t] = '0;
            TERM_UNDEF: h_in[t] = '0;
            TERM_ONE:   h_in[t] = One30;
            default:    h_in[t] = side_ff[SH-1].k_ge[t] ? u : One30 - u;
         endcase
      end
   end

   // scale by the maximum rate, then by the second term
   logic [63:0] p1, p2;
   logic [33:0] fl;
   rsp_type     res;

   always_comb begin
      p1    = 64'(max_rate_ff) * 64'(h_ff[0]) + 64'(1 << 29);
      f1_in = p1[61:30];
      p2    = 64'(f1_ff) * 64'(h2_ff) + 64'(1 << 29);
      fl    = p2[63:30];
      res.cell_tag_out   = side_ff[SM1].tag;
      res.saturated      = fl > 34'(FluxMax);
      res.flux           = res.saturated ? FluxMax : fl[RateWidth-1:0];
      res.undefined_term = (side_ff[SM1].kind_ca == TERM_UNDEF) ||
                           (side_ff[SM1].kind_ip == TERM_UNDEF);
   end

   // advance all payload stages together
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NStages; i++) side_ff[i] <= side_in[i];
         v_ff  <= v_in;
         pv_ff <= v_ff;
         pp_ff <= pp_in;
         lm_ff <= lm_in;
         lf_ff <= lf_in;
         lp_ff <= lp_in;
         dd_ff <= dd_in;
         ee_ff <= ee_in;
         ef_ff <= ef_in;
         ei_ff <= ei_in;
         dv_ff <= dv_in;
         dr_ff <= dr_in;
         dn_ff <= dn_in;
         dq_ff <= dq_in;
         ds_ff <= ds_in;
         h_ff  <= h_in;
         f1_ff <= f1_in;
         h2_ff <= h_ff[1];
      end
   end

   // output register and skid register
   logic    out_valid_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    take_new;

   assign take_new = adv && valid_ff[SM1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) skid_valid_ff <= 1'b0;
      end else if (take_new) begin
         if (!out_valid_ff || rsp_ready)
            out_valid_ff <= 1'b1;
         else
            skid_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) out_ff <= skid_ff;
      end else if (take_new) begin
         if (!out_valid_ff || rsp_ready)
            out_ff <= res;
         else
            skid_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### hdl/dhf_checker.sv
module dhf_checker import dhf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data,
   input logic                  csr_write_enable,
   input logic [IndexWidth-1:0] csr_index,
   input logic [RateWidth-1:0]  csr_data
);

   // a stalled response holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // both terms are bounded by one, so the flux never clips
   a_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.saturated)
      else $error("flux reported as saturated");

   // an undefined term forces the flux to zero
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.undefined_term |-> rsp_data.flux == '0)
      else $error("undefined term with nonzero flux");

   // no response straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind dual_hill_flux dhf_checker u_dhf_checker (.*);
